>>> design/nlcc_pkg.sv
// ----------------------------------------------------------------------------
// nlcc_pkg
// Shared constants and helpers for the NMEA line checksum checker.
// ----------------------------------------------------------------------------
package nlcc_pkg;

    localparam int BYTE_W     = 8;
    localparam int NIB_W      = 4;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    localparam logic [BYTE_W-1:0] CH_DOLLAR     = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [BYTE_W-1:0] MIN_LINE      = 8'd9;
    localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd128;

    // result word layout, lowest bit first
    localparam int RES_VALID_BIT = 0;
    localparam int RES_LEN_LSB   = 1;
    localparam int RES_CS_LSB    = 9;
    localparam int RES_TRUNC_BIT = 17;
    localparam int RES_USED_W    = 18;

    // ASCII hex digit to value; anything else is 0
    function automatic logic [NIB_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[NIB_W-1:0];
    endfunction

endpackage

>>> design/nmea_line_checksum_checker_top.sv
// ----------------------------------------------------------------------------
// nmea_line_checksum_checker_top
// Splits a byte stream into newline-terminated lines and gives one checksum
// verdict per line.
// ----------------------------------------------------------------------------
//  channel | dir | width | contents
//  s_      | in  | 8     | data_byte
//  m_      | out | 24    | line_valid, kept_length, computed_checksum,
//          |     |       | was_truncated, zero fill
//  cfg_    | in  | 8     | max_line_length
//
//  One byte per cycle: the line state updates in the cycle a request is
//  accepted, and a newline loads its verdict into the output register, seen
//  on m_ the next cycle. s_tready is low only while a verdict waits on a low
//  m_tready. Reset (synchronous, aresetn low) clears the line state, drops any
//  pending verdict and sets max_line_length to 128.
// ----------------------------------------------------------------------------
module nmea_line_checksum_checker_top
    import nlcc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BYTE_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] data_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // [0] line_valid, [8:1] kept_length, [16:9] computed_checksum,
    // [17] was_truncated, [23:18] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [BYTE_W-1:0]   max_len_reg;
    logic [BYTE_W-1:0]   count_reg, count_next;
    logic                overlong_reg, overlong_next;
    logic                dollar_reg, dollar_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic                star_seen_reg, star_seen_next;
    logic [BYTE_W-1:0]   star_pos_reg, star_pos_next;
    logic [NIB_W-1:0]    hi_nib_reg, hi_nib_next;
    logic [NIB_W-1:0]    lo_nib_reg, lo_nib_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                in_fire;
    logic [BYTE_W-1:0]   c;
    logic [BYTE_W-1:0]   limit;
    logic                keep;
    logic                star_ok;
    logic [BYTE_W-1:0]   cs;
    logic                line_ok;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign c        = s_tdata[BYTE_W-1:0];
    assign limit    = (max_len_reg == '0) ? 8'd1 : max_len_reg;
    assign keep     = count_reg < limit;

    // per-byte line state update
    always_comb begin
        count_next     = count_reg;
        overlong_next  = overlong_reg;
        dollar_next    = dollar_reg;
        xor_next       = xor_reg;
        star_seen_next = star_seen_reg;
        star_pos_next  = star_pos_reg;
        hi_nib_next    = hi_nib_reg;
        lo_nib_next    = lo_nib_reg;
        if (keep) begin
            count_next = count_reg + 8'd1;
            if (count_reg == '0) begin
                dollar_next = (c == CH_DOLLAR);
            end else if (!star_seen_reg) begin
                if (c == CH_STAR) begin
                    star_seen_next = 1'b1;
                    star_pos_next  = count_reg;
                end else begin
                    xor_next = xor_reg ^ c;
                end
            end else if ({1'b0, count_reg} == {1'b0, star_pos_reg} + 9'd1) begin
                hi_nib_next = hex_value(c);
            end else if ({1'b0, count_reg} == {1'b0, star_pos_reg} + 9'd2) begin
                lo_nib_next = hex_value(c);
            end
        end else begin
            overlong_next = 1'b1;
        end
    end

    // verdict from the state as it stands after this byte
    assign star_ok = star_seen_next &&
                     (({1'b0, star_pos_next} + 9'd3) < {1'b0, count_next});
    assign cs      = star_ok ? xor_next : '0;
    assign line_ok = (count_next >= MIN_LINE) && dollar_next && star_ok &&
                     (cs == {hi_nib_next, lo_nib_next});

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (in_fire && c == CH_NEWLINE) begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[RES_VALID_BIT]                  = line_ok;
            out_data_next[RES_LEN_LSB +: BYTE_W]          = count_next;
            out_data_next[RES_CS_LSB +: BYTE_W]           = cs;
            out_data_next[RES_TRUNC_BIT]                  = overlong_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= MAX_LEN_RESET;
            count_reg     <= '0;
            overlong_reg  <= 1'b0;
            dollar_reg    <= 1'b0;
            xor_reg       <= '0;
            star_seen_reg <= 1'b0;
            star_pos_reg  <= '0;
            hi_nib_reg    <= '0;
            lo_nib_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
            if (in_fire) begin
                if (c == CH_NEWLINE) begin
                    count_reg     <= '0;
                    overlong_reg  <= 1'b0;
                    dollar_reg    <= 1'b0;
                    xor_reg       <= '0;
                    star_seen_reg <= 1'b0;
                    star_pos_reg  <= '0;
                    hi_nib_reg    <= '0;
                    lo_nib_reg    <= '0;
                end else begin
                    count_reg     <= count_next;
                    overlong_reg  <= overlong_next;
                    dollar_reg    <= dollar_next;
                    xor_reg       <= xor_next;
                    star_seen_reg <= star_seen_next;
                    star_pos_reg  <= star_pos_next;
                    hi_nib_reg    <= hi_nib_next;
                    lo_nib_reg    <= lo_nib_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> design/nlcc_checker.sv
// ----------------------------------------------------------------------------
// nlcc_checker
// Port-level checks for the NMEA line checksum checker.
// ----------------------------------------------------------------------------
module nlcc_checker
    import nlcc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // stalled verdict holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled verdict changed or dropped");

    // a newline request yields a verdict next cycle
    a_nl_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata == CH_NEWLINE |=> m_tvalid)
        else $error("newline gave no verdict");

    // other bytes yield none
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata != CH_NEWLINE |=> !m_tvalid)
        else $error("verdict without newline");

    // a pending verdict backpressures the input
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while verdict stalled");

    // every verdict keeps a nonzero length, and a valid line is long enough
    a_valid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[RES_LEN_LSB +: BYTE_W] != '0 &&
                     (!m_tdata[RES_VALID_BIT] ||
                      m_tdata[RES_LEN_LSB +: BYTE_W] >= MIN_LINE))
        else $error("bad kept length in verdict");

endmodule

bind nmea_line_checksum_checker_top nlcc_checker u_nlcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/nmea_line_checksum_checker_top_test.sv
// ----------------------------------------------------------------------------
// nmea_line_checksum_checker_top_test
// Streams NMEA-style lines, broken lines and raw noise into the checker under
// several line-length limits. Every verdict is predicted from the bytes
// accepted and compared field by field. Both handshakes idle at random, and
// one long output hold-off forces the input to stall.
// ----------------------------------------------------------------------------
module nmea_line_checksum_checker_top_test;
    import nlcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 22;

    typedef struct packed {
        logic               ok;
        logic [BYTE_W-1:0]  len;
        logic [BYTE_W-1:0]  checksum;
        logic               truncated;
    } line_verdict_t;

    // Tracks the line being received and queues the verdict each newline owes.
    class line_scoreboard;
        logic [BYTE_W-1:0] max_len = MAX_LEN_RESET;
        int                kept = 0;
        int                star_at = 0;
        bit                dropped = 0;
        bit                dollar_first = 0;
        bit                star_found = 0;
        logic [BYTE_W-1:0] run_xor = '0;
        logic [NIB_W-1:0]  hi_nib = '0;
        logic [NIB_W-1:0]  lo_nib = '0;
        line_verdict_t     verdicts[$];
        int                lines_checked = 0;
        int                lines_valid = 0;
        int                lines_truncated = 0;
        int                errors = 0;

        function logic [NIB_W-1:0] ascii_nibble(logic [BYTE_W-1:0] c);
            if (c >= 8'h30 && c <= 8'h39) return NIB_W'(c - 8'h30);
            if (c >= 8'h41 && c <= 8'h46) return NIB_W'(c - 8'h41 + 8'd10);
            if (c >= 8'h61 && c <= 8'h66) return NIB_W'(c - 8'h61 + 8'd10);
            return '0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            int            lim;
            bit            star_ok;
            line_verdict_t v;
            lim = (max_len == 0) ? 1 : int'(max_len);
            if (kept < lim) begin
                if (kept == 0) begin
                    dollar_first = (b == CH_DOLLAR);
                end else if (!star_found) begin
                    if (b == CH_STAR) begin
                        star_found = 1'b1;
                        star_at    = kept;
                    end else begin
                        run_xor ^= b;
                    end
                end else if (kept == star_at + 1) begin
                    hi_nib = ascii_nibble(b);
                end else if (kept == star_at + 2) begin
                    lo_nib = ascii_nibble(b);
                end
                kept++;
            end else begin
                dropped = 1'b1;
            end
            if (b != CH_NEWLINE) return;

            // a star too close to the end of the kept bytes counts as no star
            star_ok     = star_found && (star_at + 3 < kept);
            v.checksum  = star_ok ? run_xor : '0;
            v.len       = BYTE_W'(kept);
            v.truncated = dropped;
            v.ok        = (kept >= MIN_LINE) && dollar_first && star_ok &&
                          (v.checksum == {hi_nib, lo_nib});
            verdicts.push_back(v);
            kept         = 0;
            star_at      = 0;
            dropped      = 1'b0;
            dollar_first = 1'b0;
            star_found   = 1'b0;
            run_xor      = '0;
            hi_nib       = '0;
            lo_nib       = '0;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] w);
            line_verdict_t got;
            line_verdict_t want;
            got.ok        = w[RES_VALID_BIT];
            got.len       = w[RES_LEN_LSB +: BYTE_W];
            got.checksum  = w[RES_CS_LSB +: BYTE_W];
            got.truncated = w[RES_TRUNC_BIT];
            if (verdicts.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected verdict valid=%0d len=%0d cs=%02h trunc=%0d",
                             got.ok, got.len, got.checksum, got.truncated);
                return;
            end
            want = verdicts.pop_front();
            lines_checked++;
            if (want.ok) lines_valid++;
            if (want.truncated) lines_truncated++;
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: line %0d expected valid=%0d len=%0d cs=%02h trunc=%0d,",
                              " got valid=%0d len=%0d cs=%02h trunc=%0d"},
                             lines_checked, want.ok, want.len, want.checksum,
                             want.truncated, got.ok, got.len, got.checksum, got.truncated);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [BYTE_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    line_scoreboard sb = new();
    bit             tx_calm = 1'b0;
    bit             rx_calm = 1'b0;
    int             hold_req = 0;
    int             bytes_sent = 0;
    int             cycle_cnt = 0;

    nmea_line_checksum_checker_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off when requested
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!tx_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_seq(input logic [BYTE_W-1:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // drop valid, wait for every owed verdict, then let the output register empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [BYTE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.max_len = v;
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] n);
        if (n < 10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // One line of bytes: mostly sentences, some broken on purpose, some noise.
    function automatic void build_line(output logic [BYTE_W-1:0] q[$]);
        int                kind;
        int                body_len;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] sum;
        q    = {};
        kind = $urandom_range(0, 99);
        if (kind >= 80 && kind < 93) begin
            // short junk or raw noise; noise may hold newlines of its own
            repeat ((kind < 85) ? $urandom_range(0, 3) : $urandom_range(1, 30)) begin
                c = $urandom_range(0, 255);
                if (kind < 85 && c == CH_NEWLINE) c = 8'h00;
                q.push_back(c);
            end
            q.push_back(CH_NEWLINE);
            return;
        end
        body_len = (kind >= 93) ? $urandom_range(100, 280) : $urandom_range(0, 20);
        if (kind >= 55 && kind < 60) begin
            c = $urandom_range(0, 255);
            if (c == CH_DOLLAR || c == CH_NEWLINE) c = 8'h21;
            q.push_back(c);
        end else begin
            q.push_back(CH_DOLLAR);
        end
        sum = '0;
        repeat (body_len) begin
            c = $urandom_range(8'h20, 8'h7E);
            if (c == CH_STAR) c = 8'h2B;
            q.push_back(c);
            sum ^= c;
        end
        if (!(kind >= 60 && kind < 65)) begin
            q.push_back(CH_STAR);
            if (kind >= 65 && kind < 70) sum ^= 8'($urandom_range(1, 255));
            if (kind >= 70 && kind < 75) begin
                // star too late: at most one digit and no CR
                repeat ($urandom_range(0, 1)) q.push_back(hex_char(sum[7:4]));
                q.push_back(CH_NEWLINE);
                return;
            end
            q.push_back(hex_char(sum[7:4]));
            if (kind >= 75 && kind < 80)
                q.push_back($urandom_range(0, 1) ? 8'h67 : 8'h5A);
            else
                q.push_back(hex_char(sum[3:0]));
        end
        if ($urandom_range(0, 1)) q.push_back(8'h0D);
        q.push_back(CH_NEWLINE);
    endfunction

    // budget runs out mid-line on purpose; the next limit applies to the rest
    task automatic run_phase(input int budget);
        logic [BYTE_W-1:0] line[$];
        int                left;
        left = budget;
        while (left > 0) begin
            build_line(line);
            for (int i = 0; i < line.size() && left > 0; i++) begin
                send_byte(line[i]);
                left--;
            end
        end
        settle();
    endtask

    initial begin
        logic [BYTE_W-1:0] seq[$];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit: empty line, shortest valid line with lowercase digits,
        // star too late
        seq = {CH_NEWLINE};
        send_seq(seq);
        seq = {8'h24, 8'h5A, 8'h45, 8'h41, 8'h2A, 8'h35, 8'h65, 8'h0D, 8'h0A};
        send_seq(seq);
        seq = {8'h24, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h2A, 8'h0D, 8'h0A};
        send_seq(seq);
        // limit lowered under a half-received line; its newline gets dropped
        seq = {8'h24, 8'h47, 8'h50};
        send_seq(seq);
        settle();
        write_limit(8'd2);
        seq = {CH_NEWLINE};
        send_seq(seq);
        settle();
        // zero limit keeps one byte
        write_limit(8'd0);
        seq = {8'hFF, CH_NEWLINE};
        send_seq(seq);
        settle();

        write_limit(MAX_LEN_RESET);
        run_phase(300);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        write_limit(8'd255);
        run_phase(260);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        write_limit(8'd9);
        run_phase(150);
        write_limit(8'd0);
        run_phase(80);
        write_limit(8'($urandom_range(10, 60)));
        hold_req = 200;
        run_phase(250);
        write_limit(8'd5);
        run_phase(100);
        write_limit(8'($urandom_range(9, 255)));
        run_phase(310);
        // close whatever line is still open
        seq = {CH_NEWLINE};
        send_seq(seq);
        settle();

        if (sb.verdicts.size() != 0) begin
            sb.errors += sb.verdicts.size();
            $display("ERROR: %0d verdicts never arrived", sb.verdicts.size());
        end
        $display("Checked %0d lines (%0d valid, %0d truncated) from %0d bytes",
                 sb.lines_checked, sb.lines_valid, sb.lines_truncated, bytes_sent);
        $display("Limits 0 to 255, mid-line limit changes, one long output hold-off");
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/nlcc_pkg.sv
design/nmea_line_checksum_checker_top.sv
design/nlcc_checker.sv
verif/nmea_line_checksum_checker_top_test.sv
